@@ hw/rtl/cpcd_pkg.sv @@
// ----------------------------------------------------------------------------
// cpcd_pkg
// Shared types and constants of the cycling power cadence decoder.
// ----------------------------------------------------------------------------
package cpcd_pkg;

  localparam int unsigned DataW     = 8;
  localparam int unsigned WordW     = 16;
  localparam int unsigned TimeW     = 32;
  localparam int unsigned IdxW      = 8;
  localparam int unsigned OffW      = 4;
  localparam int unsigned DivSteps  = WordW;
  localparam int unsigned DivCntW   = $clog2(DivSteps);
  localparam int unsigned PaddrW    = 2;
  localparam int unsigned PdataW    = 32;

  localparam logic [IdxW-1:0]  IdxMax       = '1;
  localparam logic [IdxW:0]    MinLength    = 9'd8;
  localparam logic [WordW-1:0] RpmScale     = 16'd61440;
  localparam logic [WordW-1:0] TimeoutReset = 16'd2000;

  localparam int unsigned FlagBalanceBit = 0;
  localparam int unsigned FlagTorqueBit  = 2;
  localparam int unsigned FlagWheelBit   = 4;
  localparam int unsigned FlagCrankBit   = 5;

  localparam logic [OffW-1:0] CrankBaseOff  = 4'd4;
  localparam logic [OffW-1:0] BalanceLen    = 4'd1;
  localparam logic [OffW-1:0] TorqueLen     = 4'd2;
  localparam logic [OffW-1:0] WheelLen      = 4'd6;

  localparam logic [1:0] StatusOk      = 2'd0;
  localparam logic [1:0] StatusShort   = 2'd1;
  localparam logic [1:0] StatusMissing = 2'd2;
  localparam logic [1:0] StatusUnused  = 2'd3;

  localparam logic [PaddrW-1:0] AddrTimeout = 2'd0;

  typedef struct packed {
    logic [DataW-1:0] data_byte;
    logic             last_byte;
    logic [TimeW-1:0] now_ms;
  } cpcd_in_t;

  typedef struct packed {
    logic signed [WordW-1:0] power_watts;
    logic [WordW-1:0]        cadence_rpm;
    logic                    crank_data_present;
    logic [1:0]              status;
  } cpcd_out_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic load;
    logic step;
    logic fin;
  } cpcd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic out_free;
  } cpcd_sts_t;

endpackage

@@ hw/rtl/cpcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// cpcd_ctrl
// Sequencer: byte capture, multiply, divide steps and result hand-off.
// ----------------------------------------------------------------------------
module cpcd_ctrl import cpcd_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  input  logic      in_last_i,
  input  cpcd_sts_t sts_i,
  output cpcd_cmd_t cmd_o,
  output logic      in_stall_o
);

  typedef enum logic [2:0] {
    StIdle,
    StMul,
    StLoad,
    StDiv,
    StFin
  } state_e;

  state_e               state_q;
  logic [DivCntW-1:0]   cnt_q;
  logic                 accept;

  assign in_stall_o = (state_q != StIdle);
  assign accept     = in_valid_i && (state_q == StIdle);

  always_comb begin
    cmd_o         = '0;
    cmd_o.capture = accept;
    cmd_o.mul     = (state_q == StMul);
    cmd_o.load    = (state_q == StLoad);
    cmd_o.step    = (state_q == StDiv);
    cmd_o.fin     = (state_q == StFin) && sts_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        StIdle: begin
          if (accept && in_last_i) begin
            state_q <= sts_i.need_div ? StMul : StFin;
          end
        end
        StMul: begin
          state_q <= StLoad;
        end
        StLoad: begin
          state_q <= StDiv;
          cnt_q   <= DivCntW'(DivSteps - 1);
        end
        StDiv: begin
          if (cnt_q == '0) begin
            state_q <= StFin;
          end else begin
            cnt_q <= cnt_q - 1'b1;
          end
        end
        StFin: begin
          if (sts_i.out_free) begin
            state_q <= StIdle;
          end
        end
        default: begin
          state_q <= StIdle;
        end
      endcase
    end
  end

endmodule

@@ hw/rtl/cpcd_dp.sv @@
// ----------------------------------------------------------------------------
// cpcd_dp
// Datapath: field capture, crank state, cadence divider and result register.
// ----------------------------------------------------------------------------
module cpcd_dp import cpcd_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  cpcd_in_t         in_item_i,
  input  logic [WordW-1:0] timeout_i,
  input  cpcd_cmd_t        cmd_i,
  output cpcd_sts_t        sts_o,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output cpcd_out_t        out_item_o
);

  logic [IdxW-1:0]  idx_q;
  logic [WordW-1:0] flags_q, power_q, revs_q, evt_q;
  logic [WordW-1:0] flags_d, power_d, revs_d, evt_d;
  logic [WordW-1:0] prev_revs_q, prev_evt_q;
  logic             prev_revs_vld_q, prev_evt_vld_q;
  logic [TimeW-1:0] last_ms_q;

  logic [OffW-1:0]  off_cur, off_fin;
  logic [IdxW:0]    length;
  logic             too_short, missing, crank, upd, stale;
  logic [WordW-1:0] d_rev, d_evt;
  logic [1:0]       status_n;

  logic signed [WordW-1:0] res_power_q;
  logic [1:0]              res_status_q;
  logic                    res_crank_q;
  logic                    div_used_q;
  logic [WordW-1:0]        d_rev_q, d_evt_q;
  logic [TimeW-1:0]        prod_q;
  logic [WordW-1:0]        rem_q, quo_q;
  logic                    sat_q;
  logic [WordW:0]          trial;
  logic                    ge;

  logic      out_valid_q;
  cpcd_out_t out_q;

  function automatic logic [OffW-1:0] crank_off(logic [WordW-1:0] f);
    logic [OffW-1:0] o;
    o = CrankBaseOff;
    if (f[FlagBalanceBit]) o = o + BalanceLen;
    if (f[FlagTorqueBit])  o = o + TorqueLen;
    if (f[FlagWheelBit])   o = o + WheelLen;
    return o;
  endfunction

  assign off_cur = crank_off(flags_q);

  always_comb begin
    flags_d = flags_q;
    power_d = power_q;
    revs_d  = revs_q;
    evt_d   = evt_q;
    if (idx_q != IdxMax) begin
      case (idx_q)
        8'd0: flags_d = {8'h00, in_item_i.data_byte};
        8'd1: flags_d[15:8] = in_item_i.data_byte;
        8'd2: power_d = {8'h00, in_item_i.data_byte};
        8'd3: power_d[15:8] = in_item_i.data_byte;
        default: begin
          if (idx_q == IdxW'(off_cur)) begin
            revs_d = {8'h00, in_item_i.data_byte};
          end else if (idx_q == IdxW'(off_cur) + 8'd1) begin
            revs_d[15:8] = in_item_i.data_byte;
          end else if (idx_q == IdxW'(off_cur) + 8'd2) begin
            evt_d = {8'h00, in_item_i.data_byte};
          end else if (idx_q == IdxW'(off_cur) + 8'd3) begin
            evt_d[15:8] = in_item_i.data_byte;
          end
        end
      endcase
    end
  end

  assign off_fin   = crank_off(flags_d);
  assign length    = {1'b0, idx_q} + 9'd1;
  assign too_short = (length < MinLength);
  assign missing   = (length < ((IdxW+1)'(off_fin) + 9'd4));
  assign crank     = flags_d[FlagCrankBit];
  assign upd       = crank && !too_short && !missing;
  assign d_rev     = revs_d - prev_revs_q;
  assign d_evt     = evt_d - prev_evt_q;
  assign stale     = ((in_item_i.now_ms - last_ms_q) > {16'h0000, timeout_i});

  always_comb begin
    if (too_short) begin
      status_n = StatusShort;
    end else if (crank && missing) begin
      status_n = StatusMissing;
    end else begin
      status_n = StatusOk;
    end
  end

  assign sts_o.need_div = upd && prev_evt_vld_q && prev_revs_vld_q &&
                          (d_evt != '0) && !stale;
  assign sts_o.out_free = !out_valid_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q           <= '0;
      flags_q         <= '0;
      power_q         <= '0;
      revs_q          <= '0;
      evt_q           <= '0;
      prev_revs_q     <= '0;
      prev_evt_q      <= '0;
      prev_revs_vld_q <= 1'b0;
      prev_evt_vld_q  <= 1'b0;
      last_ms_q       <= '0;
    end else if (cmd_i.capture) begin
      if (in_item_i.last_byte) begin
        idx_q   <= '0;
        flags_q <= '0;
        power_q <= '0;
        revs_q  <= '0;
        evt_q   <= '0;
        if (upd) begin
          prev_revs_q     <= revs_d;
          prev_revs_vld_q <= 1'b1;
          if (!prev_evt_vld_q || (prev_evt_q != evt_d)) begin
            prev_evt_q     <= evt_d;
            prev_evt_vld_q <= 1'b1;
            last_ms_q      <= in_item_i.now_ms;
          end
        end
      end else begin
        if (idx_q != IdxMax) begin
          idx_q <= idx_q + 1'b1;
        end
        flags_q <= flags_d;
        power_q <= power_d;
        revs_q  <= revs_d;
        evt_q   <= evt_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture && in_item_i.last_byte) begin
      res_power_q  <= too_short ? '0 : power_d;
      res_status_q <= status_n;
      res_crank_q  <= crank;
      div_used_q   <= sts_o.need_div;
      d_rev_q      <= d_rev;
      d_evt_q      <= d_evt;
    end
  end

  assign trial = {rem_q, quo_q[WordW-1]};
  assign ge    = (trial >= {1'b0, d_evt_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      prod_q <= {16'h0000, d_rev_q} * {16'h0000, RpmScale};
    end
    if (cmd_i.load) begin
      rem_q <= prod_q[TimeW-1:WordW];
      quo_q <= prod_q[WordW-1:0];
      sat_q <= (prod_q[TimeW-1:WordW] >= d_evt_q);
    end else if (cmd_i.step) begin
      rem_q <= ge ? WordW'(trial - {1'b0, d_evt_q}) : trial[WordW-1:0];
      quo_q <= {quo_q[WordW-2:0], ge};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.fin) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) begin
      out_q.power_watts        <= res_power_q;
      out_q.cadence_rpm        <= div_used_q ? (sat_q ? '1 : quo_q) : '0;
      out_q.crank_data_present <= res_crank_q;
      out_q.status             <= res_status_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

endmodule

@@ hw/rtl/cycling_power_cadence_decoder.sv @@
// ----------------------------------------------------------------------------
// cycling_power_cadence_decoder
// Decodes a cycling power measurement notification byte by byte and gives
// power, status and crank cadence on the last byte.
//
//   channel  | dir | handshake              | payload
//   ---------+-----+------------------------+-------------------------------
//   in       | in  | in_valid_i/in_stall_o  | in_item_i (byte, last, time)
//   out      | out | out_valid_o/out_stall_i| out_item_o (power, cadence,..)
//   config   | in  | apb psel/penable       | stale timeout, 16 bit
//
// non-final bytes are taken back to back; a final byte is followed by
// multiply, load and the 16-step shift-subtract divider when cadence needs
// it, then the result hand-off; input stalls until that hand-off, which
// waits while the one-item output register is full and stalled
// reset clears control, crank and valid state; timeout returns to 2000 ms
// ----------------------------------------------------------------------------
module cycling_power_cadence_decoder import cpcd_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  cpcd_in_t          in_item_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output cpcd_out_t         out_item_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [PaddrW-1:0] paddr,
  input  logic [PdataW-1:0] pwdata,
  output logic [PdataW-1:0] prdata,
  output logic              pready
);

  logic [WordW-1:0] timeout_q;
  cpcd_cmd_t        cmd;
  cpcd_sts_t        sts;

  assign pready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      timeout_q <= TimeoutReset;
    end else if (psel && penable && pwrite && (paddr == AddrTimeout)) begin
      timeout_q <= pwdata[WordW-1:0];
    end
  end

  assign prdata = (paddr == AddrTimeout) ? {16'h0000, timeout_q} : '0;

  cpcd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_item_i.last_byte),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  cpcd_dp u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .timeout_i   (timeout_q),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o)
  );

`ifndef SYNTHESIS
  a_last_stalls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o && in_item_i.last_byte) |=> in_stall_o)
    else $error("decoder took a byte right after a final byte");

  a_no_cadence_on_error: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((out_item_o.status == StatusOk) || (out_item_o.cadence_rpm == '0)))
    else $error("cadence given with error status");

  a_short_power_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_item_o.status == StatusShort)) |-> (out_item_o.power_watts == '0))
    else $error("power given for short notification");

  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_item_o.status != StatusUnused))
    else $error("unused status code");
`endif

endmodule
